[design/pes_pkg.sv]
// Shared codes, state encoding and controller/datapath interface types.
package pes_pkg;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic KIND_FIRED   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [15:0] RESET_MAX_WAIT_MS = 16'd350;

  localparam int REM_STEPS = 32;
  localparam int REM_CNT_W = $clog2(REM_STEPS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DIV,
    S_FIRE,
    S_SUMMARY
  } pes_state_t;

  typedef struct packed {
    logic accept;
    logic walk_next;
    logic check;
    logic div_start;
    logic fire;
    logic finish;
  } pes_cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic [1:0] op;
    logic       last_idx;
    logic       active;
    logic       due_le_now;
    logic       div_busy;
    logic       out_free;
  } pes_stat_t;

endpackage

[design/pes_rem.sv]
// Bit-serial restoring remainder unit: 32-bit dividend modulo 16-bit divisor.
module pes_rem (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [15:0] rem
);
  import pes_pkg::*;

  logic [31:0]          dq;
  logic [15:0]          divisor_q;
  logic [REM_CNT_W-1:0] cnt;
  logic [16:0]          rem_sh;
  logic                 fits;
  logic [15:0]          rem_next;

  always_comb begin
    rem_sh   = {rem, dq[31]};
    fits     = rem_sh >= {1'b0, divisor_q};
    rem_next = fits ? 16'(rem_sh - {1'b0, divisor_q}) : rem_sh[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= REM_CNT_W'(REM_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == REM_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq        <= dividend;
      divisor_q <= divisor;
      rem       <= '0;
    end else if (busy) begin
      dq  <= {dq[30:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

[design/pes_ctrl.sv]
// Controller state machine that sequences the table walk for each input beat.
module pes_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  pes_pkg::pes_stat_t stat,
  output pes_pkg::pes_cmd_t  cmd,
  output logic              idle
);
  import pes_pkg::*;

  pes_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    idle       = 1'b0;
    unique case (state)
      S_IDLE: begin
        idle = 1'b1;
        if (item_valid) begin
          cmd.accept = 1'b1;
          if (stat.in_op == OP_CREATE || stat.in_op == OP_UPDATE ||
              stat.in_op == OP_TICK) begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.op == OP_TICK && stat.active && stat.due_le_now) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.check = 1'b1;
          if (stat.last_idx) begin
            state_next = S_SUMMARY;
          end else begin
            cmd.walk_next = 1'b1;
            state_next    = S_READ;
          end
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_next = S_FIRE;
        end
      end
      S_FIRE: begin
        if (stat.out_free) begin
          cmd.fire = 1'b1;
          if (stat.last_idx) begin
            state_next = S_SUMMARY;
          end else begin
            cmd.walk_next = 1'b1;
            state_next    = S_READ;
          end
        end
      end
      S_SUMMARY: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[design/pes_dp.sv]
// Datapath: entry table, walk index, search flags, delay minimum and result register.
module pes_dp #(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  pes_pkg::pes_cmd_t  cmd,
  output pes_pkg::pes_stat_t stat,
  input  logic [1:0]        op,
  input  logic [15:0]       event_key,
  input  logic [15:0]       period_ms,
  input  logic [15:0]       start_due_ms,
  input  logic [31:0]       now_ms,
  input  logic              cfg_write_en,
  input  logic [15:0]       cfg_write_data,
  output logic              result_valid,
  input  logic              result_stall,
  output logic              kind,
  output logic [15:0]       fired_key,
  output logic [1:0]        status,
  output logic [15:0]       next_delay_ms,
  output logic              last
);
  import pes_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Latched input beat.
  logic [1:0]  op_q;
  logic [15:0] key_q;
  logic [15:0] period_q;
  logic [15:0] start_q;
  logic [31:0] now_q;

  logic [15:0] max_wait;
  logic [15:0] best;

  logic [IW-1:0] idx;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic          free_found;
  logic [IW-1:0] free_idx;

  logic [ENTRIES-1:0] valid;
  logic [15:0] mem_key    [ENTRIES];
  logic [15:0] mem_period [ENTRIES];
  logic [31:0] mem_due    [ENTRIES];

  logic        rd_valid;
  logic [15:0] rd_key;
  logic [15:0] rd_period;
  logic [31:0] rd_due;

  logic        div_busy;
  logic [15:0] rem;

  logic        out_free;
  logic        create_wr;
  logic        update_wr;
  logic        key_we;
  logic        period_we;
  logic        due_we;
  logic [IW-1:0] wr_addr;
  logic [31:0] due_wdata;
  logic [31:0] due_gap;
  logic [15:0] fire_delay;
  logic [31:0] due_new;
  logic [1:0]  summary_status;

  pes_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (now_q - rd_due),
    .divisor  (rd_period),
    .busy     (div_busy),
    .rem      (rem)
  );

  always_comb begin
    out_free   = !result_valid || !result_stall;
    create_wr  = cmd.finish && op_q == OP_CREATE && !hit && free_found;
    update_wr  = cmd.finish && op_q == OP_UPDATE && hit;
    key_we     = create_wr;
    period_we  = create_wr || update_wr;
    due_we     = create_wr || update_wr || cmd.fire;
    fire_delay = rd_period - rem;
    due_new    = now_q + {16'd0, fire_delay};
    due_gap    = rd_due - now_q;
    if (cmd.fire) begin
      wr_addr = idx;
    end else if (op_q == OP_CREATE) begin
      wr_addr = free_idx;
    end else begin
      wr_addr = hit_idx;
    end
    due_wdata = cmd.fire ? due_new : {16'd0, start_q};

    if (op_q == OP_CREATE) begin
      if (hit) begin
        summary_status = ST_DUPLICATE;
      end else if (free_found) begin
        summary_status = ST_OK;
      end else begin
        summary_status = ST_FULL;
      end
    end else if (op_q == OP_UPDATE) begin
      summary_status = hit ? ST_OK : ST_NOT_FOUND;
    end else begin
      summary_status = ST_OK;
    end

    stat.in_op      = op;
    stat.op         = op_q;
    stat.last_idx   = idx == IW'(ENTRIES - 1);
    stat.active     = rd_valid && rd_period != 16'd0;
    stat.due_le_now = rd_due <= now_q;
    stat.div_busy   = div_busy;
    stat.out_free   = out_free;
  end

  // Table memories with a registered read at the walk index.
  always_ff @(posedge clk) begin
    if (key_we) begin
      mem_key[wr_addr] <= key_q;
    end
    if (period_we) begin
      mem_period[wr_addr] <= period_q;
    end
    if (due_we) begin
      mem_due[wr_addr] <= due_wdata;
    end
    rd_key    <= mem_key[idx];
    rd_period <= mem_period[idx];
    rd_due    <= mem_due[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (create_wr) begin
        valid[free_idx] <= 1'b1;
      end
      rd_valid <= valid[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_wait <= RESET_MAX_WAIT_MS;
    end else if (cfg_write_en) begin
      max_wait <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= op;
      key_q    <= event_key;
      period_q <= period_ms;
      start_q  <= start_due_ms;
      now_q    <= now_ms;
    end
  end

  // Walk index, search flags and running minimum delay.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.accept) begin
      idx        <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (cmd.walk_next) begin
        idx <= idx + 1'b1;
      end
      if (cmd.check && op_q != OP_TICK) begin
        if (rd_valid && rd_key == key_q && !hit) begin
          hit <= 1'b1;
        end
        if (!rd_valid && !free_found) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      best <= max_wait;
    end else if (cmd.check && op_q == OP_TICK && stat.active) begin
      if (due_gap < {16'd0, best}) begin
        best <= due_gap[15:0];
      end
    end else if (cmd.fire) begin
      if (fire_delay < best) begin
        best <= fire_delay;
      end
    end
    if (cmd.check && op_q != OP_TICK) begin
      if (rd_valid && rd_key == key_q && !hit) begin
        hit_idx <= idx;
      end
      if (!rd_valid && !free_found) begin
        free_idx <= idx;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.fire || cmd.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      kind          <= KIND_FIRED;
      fired_key     <= rd_key;
      status        <= ST_OK;
      next_delay_ms <= 16'd0;
      last          <= 1'b0;
    end else if (cmd.finish) begin
      kind          <= KIND_SUMMARY;
      fired_key     <= 16'd0;
      status        <= summary_status;
      next_delay_ms <= (op_q == OP_TICK) ? best : 16'd0;
      last          <= 1'b1;
    end
  end

endmodule

[design/periodic_event_scheduler_unit.sv]
// Top level of the periodic event scheduler: controller plus datapath.
//
// Usage: an input beat on the item channel (item_valid/item_stall) carries a
// create, update or tick operation. A create adds a key to the lowest free
// entry, an update rewrites period and due time of a known key, and a tick
// fires every enabled entry whose due time is reached and reports the capped
// delay to the earliest due time. Results leave one beat at a time on the
// result channel (result_valid/result_stall); the last beat of each input
// has last set. Operation code 3 is dropped and produces no beat.
// The table is walked one entry at a time through the registered read port
// of the entry memories, each entry passing a read state and a check state.
// On a tick each firing entry also runs the bit-serial remainder unit before
// its beat is loaded. One input is worked on at a time; item_stall is high
// from acceptance until the summary beat has been loaded into the result
// register, so the next input can be taken while that beat still waits.
// When the receiver stalls, the walk halts before loading the next beat.
// A synchronous reset clears all entries, the result register and loads the
// maximum wait register with 350 ms; max_wait is written via cfg_write_en.
module periodic_event_scheduler_unit #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  op,
  input  logic [15:0] event_key,
  input  logic [15:0] period_ms,
  input  logic [15:0] start_due_ms,
  input  logic [31:0] now_ms,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        kind,
  output logic [15:0] fired_key,
  output logic [1:0]  status,
  output logic [15:0] next_delay_ms,
  output logic        last
);
  import pes_pkg::*;

  pes_cmd_t  cmd;
  pes_stat_t stat;
  logic      idle;
  logic      item_valid_seen;

  // The controller only takes a beat while idle, so stall is its inverse.
  assign item_stall      = !idle;
  assign item_valid_seen = item_valid && idle;

  pes_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid_seen),
    .stat       (stat),
    .cmd        (cmd),
    .idle       (idle)
  );

  pes_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .op             (op),
    .event_key      (event_key),
    .period_ms      (period_ms),
    .start_due_ms   (start_due_ms),
    .now_ms         (now_ms),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .kind           (kind),
    .fired_key      (fired_key),
    .status         (status),
    .next_delay_ms  (next_delay_ms),
    .last           (last)
  );

endmodule

[tb/pes_result_checker.sv]
// Result checker for the periodic event scheduler: entry table prediction and beat comparison.
module pes_result_checker #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic [1:0]  op,
  input  logic [15:0] event_key,
  input  logic [15:0] period_ms,
  input  logic [15:0] start_due_ms,
  input  logic [31:0] now_ms,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic        kind,
  input  logic [15:0] fired_key,
  input  logic [1:0]  status,
  input  logic [15:0] next_delay_ms,
  input  logic        last,
  output int          mismatch_count,
  output int          beats_owed
);
  import pes_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [15:0] key;
    logic [1:0]  status;
    logic [15:0] delay;
    logic        last;
  } sched_beat_t;

  // Shadow copy of the entry table and of the delay cap.
  logic        tbl_valid  [ENTRIES];
  logic [15:0] tbl_key    [ENTRIES];
  logic [15:0] tbl_period [ENTRIES];
  logic [31:0] tbl_due    [ENTRIES];
  logic [15:0] wait_cap;

  sched_beat_t owed_beats[$];
  sched_beat_t got_beat;
  sched_beat_t want_beat;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  function automatic sched_beat_t make_beat(input logic b_kind, input logic [15:0] b_key,
                                            input logic [1:0] b_status,
                                            input logic [15:0] b_delay, input logic b_last);
    sched_beat_t b;
    b.kind   = b_kind;
    b.key    = b_key;
    b.status = b_status;
    b.delay  = b_delay;
    b.last   = b_last;
    return b;
  endfunction

  // Applies one accepted item to the shadow table and queues the beats it owes.
  task automatic schedule_item(input logic [1:0] p_op, input logic [15:0] p_key,
                               input logic [15:0] p_period, input logic [15:0] p_start,
                               input logic [31:0] p_now);
    int          hit;
    int          free_slot;
    int          i;
    logic [31:0] rem;
    logic [32:0] next_due;
    logic [32:0] span;
    logic [32:0] best;
    hit = -1;
    free_slot = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_key[i] == p_key && hit < 0) hit = i;
      if (!tbl_valid[i] && free_slot < 0) free_slot = i;
    end
    case (p_op)
      OP_CREATE: begin
        if (hit >= 0) begin
          owed_beats.push_back(make_beat(KIND_SUMMARY, 16'd0, ST_DUPLICATE, 16'd0, 1'b1));
        end else if (free_slot < 0) begin
          owed_beats.push_back(make_beat(KIND_SUMMARY, 16'd0, ST_FULL, 16'd0, 1'b1));
        end else begin
          tbl_valid[free_slot]  = 1'b1;
          tbl_key[free_slot]    = p_key;
          tbl_period[free_slot] = p_period;
          tbl_due[free_slot]    = {16'd0, p_start};
          owed_beats.push_back(make_beat(KIND_SUMMARY, 16'd0, ST_OK, 16'd0, 1'b1));
        end
      end
      OP_UPDATE: begin
        if (hit < 0) begin
          owed_beats.push_back(make_beat(KIND_SUMMARY, 16'd0, ST_NOT_FOUND, 16'd0, 1'b1));
        end else begin
          tbl_period[hit] = p_period;
          tbl_due[hit]    = {16'd0, p_start};
          owed_beats.push_back(make_beat(KIND_SUMMARY, 16'd0, ST_OK, 16'd0, 1'b1));
        end
      end
      OP_TICK: begin
        best = {17'd0, wait_cap};
        for (i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i] && tbl_period[i] != 16'd0) begin
            if (tbl_due[i] <= p_now) begin
              // Realign onto the period grid; the delay is taken before the wrap.
              rem      = (p_now - tbl_due[i]) % {16'd0, tbl_period[i]};
              next_due = {1'b0, p_now} + {17'd0, tbl_period[i]} - {1'b0, rem};
              tbl_due[i] = next_due[31:0];
              span     = next_due - {1'b0, p_now};
              owed_beats.push_back(make_beat(KIND_FIRED, tbl_key[i], ST_OK, 16'd0, 1'b0));
            end else begin
              span = {1'b0, tbl_due[i] - p_now};
            end
            if (span < best) best = span;
          end
        end
        owed_beats.push_back(make_beat(KIND_SUMMARY, 16'd0, ST_OK, best[15:0], 1'b1));
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tbl_valid[i]  = 1'b0;
        tbl_key[i]    = 16'd0;
        tbl_period[i] = 16'd0;
        tbl_due[i]    = 32'd0;
      end
      wait_cap = RESET_MAX_WAIT_MS;
      owed_beats.delete();
      beats_owed = 0;
    end else begin
      if (cfg_write_en) wait_cap = cfg_write_data;
      if (result_valid && !result_stall) begin
        got_beat = make_beat(kind, fired_key, status, next_delay_ms, last);
        if (owed_beats.size() == 0) begin
          report_mismatch($sformatf(
            "unexpected beat kind=%0d key=%h status=%0d delay=%0d last=%0d",
            kind, fired_key, status, next_delay_ms, last));
        end else begin
          want_beat = owed_beats.pop_front();
          if (got_beat.kind !== want_beat.kind || got_beat.key !== want_beat.key ||
              got_beat.status !== want_beat.status || got_beat.delay !== want_beat.delay ||
              got_beat.last !== want_beat.last) begin
            report_mismatch($sformatf(
              "want kind=%0d key=%h st=%0d delay=%0d last=%0d, got %0d %h %0d %0d %0d",
              want_beat.kind, want_beat.key, want_beat.status, want_beat.delay, want_beat.last,
              got_beat.kind, got_beat.key, got_beat.status, got_beat.delay, got_beat.last));
          end
        end
      end
      if (item_valid && !item_stall) begin
        schedule_item(op, event_key, period_ms, start_due_ms, now_ms);
      end
      beats_owed = owed_beats.size();
    end
  end

endmodule

[tb/tb_periodic_event_scheduler_unit.sv]
// Testbench top for the periodic event scheduler: stimulus, handshake pacing and verdict.
module tb_periodic_event_scheduler_unit;
  import pes_pkg::*;

  // Operation code 3 is not defined by the block; it must be dropped silently.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Cycles allowed after the last result before the block is considered idle.
  // A create or update walks the whole table well within this tail.
  localparam int DRAIN_TAIL = 100;

  // The longest legal quiet stretch is the long receiver hold or the walk
  // between two beats of a tick, so reaching QUIET_LIMIT without a single
  // beat can only mean the block is stuck.
  localparam int QUIET_LIMIT = 20000;
  localparam int LONG_HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [15:0] cfg_write_data = 16'd0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  op = OP_CREATE;
  logic [15:0] event_key = 16'd0;
  logic [15:0] period_ms = 16'd0;
  logic [15:0] start_due_ms = 16'd0;
  logic [31:0] now_ms = 32'd0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        kind;
  logic [15:0] fired_key;
  logic [1:0]  status;
  logic [15:0] next_delay_ms;
  logic        last;

  int mismatches;
  int beats_owed;

  // Pacing knobs: percent of cycles in which each side holds back.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long receiver hold, requested by the stimulus and counted by the receiver.
  bit long_hold_req  = 1'b0;
  bit long_hold_done = 1'b0;
  int hold_left      = 0;

  // An item beat was taken at the last rising edge (sampled before the edge).
  logic item_taken = 1'b0;
  int   quiet_cycles = 0;

  // Keys known to sit in the table once the directed part has filled it.
  logic [15:0] known_keys[$];
  // Running time base for tick beats.
  logic [31:0] sim_now = 32'd0;

  always #10 clk = ~clk;

  periodic_event_scheduler_unit #(.ENTRIES(16)) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .op            (op),
    .event_key     (event_key),
    .period_ms     (period_ms),
    .start_due_ms  (start_due_ms),
    .now_ms        (now_ms),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .kind          (kind),
    .fired_key     (fired_key),
    .status        (status),
    .next_delay_ms (next_delay_ms),
    .last          (last)
  );

  pes_result_checker #(.ENTRIES(16)) beat_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .op            (op),
    .event_key     (event_key),
    .period_ms     (period_ms),
    .start_due_ms  (start_due_ms),
    .now_ms        (now_ms),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .kind          (kind),
    .fired_key     (fired_key),
    .status        (status),
    .next_delay_ms (next_delay_ms),
    .last          (last),
    .mismatch_count(mismatches),
    .beats_owed    (beats_owed)
  );

  // The nonblocking update picks up the handshake as it stood just before the
  // edge, so the sender can read it safely at the following falling edge.
  always @(posedge clk) begin
    item_taken <= item_valid && !item_stall;
  end

  // Watchdog: counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stalls at the current rate, plus one long hold on request.
  // During the long hold the block cannot unload, so once its next beat is due
  // it keeps its input stalled while the sender goes on offering the next item.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      result_stall <= 1'b1;
      hold_left = LONG_HOLD_CYCLES - 1;
      long_hold_done = 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Offers one item beat and returns at the falling edge after it was taken.
  // Valid stays high on return, so back-to-back beats follow without a gap;
  // the next call either drops valid for idle cycles or loads a new item.
  task automatic send_item(input logic [1:0] s_op, input logic [15:0] s_key,
                           input logic [15:0] s_period, input logic [15:0] s_start,
                           input logic [31:0] s_now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid   <= 1'b1;
    op           <= s_op;
    event_key    <= s_key;
    period_ms    <= s_period;
    start_due_ms <= s_start;
    now_ms       <= s_now;
    do @(negedge clk); while (!item_taken);
  endtask

  // Holds the sender back until every owed beat has arrived, then waits a
  // tail of cycles. At least one falling edge passes, so valid is never
  // dropped and raised again in the same time step.
  task automatic drain(input int tail);
    item_valid <= 1'b0;
    do @(negedge clk); while (beats_owed != 0);
    repeat (tail) @(negedge clk);
  endtask

  // Writes the delay cap; the caller has drained the block first.
  task automatic set_wait_cap(input logic [15:0] cap);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= cap;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // Periods are mostly short so that entries fire often; a few are disabled
  // and a few span the whole field.
  function automatic logic [15:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'd0;
    if (r < 85) return 16'($urandom_range(1, 400));
    if (r < 95) return 16'($urandom_range(1, 5000));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Half the due times land just ahead of the current time, the rest anywhere.
  function automatic logic [15:0] pick_start();
    if ($urandom_range(0, 1)) return sim_now[15:0] + 16'($urandom_range(0, 600));
    return 16'($urandom_range(0, 65535));
  endfunction

  // One random item. The table is full after the directed part, so creates
  // either hit a known key or report a full table; updates mostly hit a
  // known key; ticks move the time base forward with occasional jumps,
  // including jumps to the top of the 32-bit range where due times wrap.
  task automatic random_item(output bit counted);
    int          pick;
    int          r;
    logic [15:0] k;
    pick = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 15) begin
      if ($urandom_range(0, 1)) k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      else k = 16'($urandom_range(0, 65535));
      send_item(OP_CREATE, k, pick_period(), pick_start(), $urandom());
    end else if (pick < 50) begin
      if ($urandom_range(0, 99) < 85) k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      else k = 16'($urandom_range(0, 65535));
      send_item(OP_UPDATE, k, pick_period(), pick_start(), $urandom());
    end else if (pick < 95) begin
      r = $urandom_range(0, 99);
      if (r < 2) sim_now = 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
      else if (r < 5) sim_now = $urandom();
      else if (r < 11) sim_now = 32'($urandom_range(0, 3000));
      else sim_now = sim_now + 32'($urandom_range(0, 250));
      send_item(OP_TICK, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), sim_now);
    end else begin
      // Dropped by the block, so it does not count toward the item total.
      send_item(OP_UNUSED, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), $urandom());
      counted = 1'b0;
    end
  endtask

  // A run of random items. With pressure set, the receiver holds off for a
  // long stretch early on, and later the sender pauses until all owed beats
  // have come back.
  task automatic random_phase(input int item_goal, input bit pressure);
    int done_items;
    bit counted;
    done_items = 0;
    while (done_items < item_goal) begin
      if (pressure && done_items == 10) long_hold_req = 1'b1;
      if (pressure && done_items == 60) drain(0);
      random_item(counted);
      if (counted) done_items++;
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, run with the first pacing mix and the reset delay cap.
    send_idle_pct = 9;
    recv_idle_pct = 47;
    // An empty table reports the cap as the delay.
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 32'd0);
    // A disabled entry at the lowest key, then one with every field at its top.
    send_item(OP_CREATE, 16'h0000, 16'h0000, 16'h0000, 32'd0);
    send_item(OP_CREATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    known_keys.push_back(16'h0000);
    known_keys.push_back(16'hFFFF);
    // Duplicate key on create and an update of a key that is not present.
    send_item(OP_CREATE, 16'hFFFF, 16'h0001, 16'h0001, 32'd0);
    send_item(OP_UPDATE, 16'h1234, 16'h0064, 16'h0032, 32'd0);
    // Enable the first entry, then tick before, exactly at and past its due time.
    send_item(OP_UPDATE, 16'h0000, 16'd100, 16'd50, 32'd0);
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 32'd0);
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 32'd50);
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 32'd1000);
    // Time at its maximum: both entries fire and their realigned due times wrap.
    send_item(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    // The unused operation code with every bit set.
    send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    // Fill the remaining slots, then one more create finds the table full.
    for (int i = 0; i < 14; i++) begin
      send_item(OP_CREATE, 16'h0001 << i, 16'(i * 37 + 3), 16'(i * 25), 32'd0);
      known_keys.push_back(16'h0001 << i);
    end
    send_item(OP_CREATE, 16'h5A5A, 16'd10, 16'd10, 32'd0);
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 32'd500);

    // Largest cap: the sender idles rarely and the receiver often.
    drain(DRAIN_TAIL);
    set_wait_cap(16'hFFFF);
    random_phase(115, 1'b0);

    // Smallest cap, with the idling swapped between the two sides.
    drain(DRAIN_TAIL);
    set_wait_cap(16'd1);
    send_idle_pct = 47;
    recv_idle_pct = 9;
    random_phase(115, 1'b0);

    // A cap in between, no idling on either side, plus the pressure cases.
    drain(DRAIN_TAIL);
    set_wait_cap(16'($urandom_range(2, 65534)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(115, 1'b1);

    drain(DRAIN_TAIL);
    if (mismatches == 0 && beats_owed == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
